[rtl/lcdsf_pkg.sv]
// Shared types and constants for the serial LCD frame transmitter.
// Used by the channel interfaces and by every module of the block.
package lcdsf_pkg;

   localparam int FRAME_BITS = 17;
   localparam int COUNT_W    = $clog2(FRAME_BITS + 1);

   typedef logic [COUNT_W-1:0]    count_type;
   typedef logic [FRAME_BITS-1:0] frame_type;

   localparam logic [1:0] OP_COMMAND = 2'd0;
   localparam logic [1:0] OP_SINGLE  = 2'd1;
   localparam logic [1:0] OP_BURST   = 2'd2;

   localparam logic [3:0] CMD_PREAMBLE   = 4'h8;
   localparam logic [2:0] WRITE_PREAMBLE = 3'h5;

   localparam count_type CMD_BITS        = count_type'(12);
   localparam count_type SINGLE_BITS     = count_type'(13);
   localparam count_type BURST_OPEN_BITS = count_type'(17);
   localparam count_type BURST_DATA_BITS = count_type'(8);

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] command_code;
      logic [5:0] address;
      logic [7:0] data_byte;
      logic       last_of_burst;
   } req_type;

   typedef struct packed {
      logic data_bit;
      logic frame_start;
      logic frame_end;
      logic last;
   } rsp_type;

   // One frame ready to leave: bits left aligned, first bit in the top position.
   typedef struct packed {
      frame_type bits;
      count_type count;
      logic      starts;
      logic      ends;
   } load_type;

   function automatic logic [7:0] reverse_byte(input logic [7:0] value);
      logic [7:0] result;
      for (int i = 0; i < 8; i++) begin
         result[i] = value[7 - i];
      end
      return result;
   endfunction

endpackage

[rtl/lcdsf_if.sv]
// Valid/ready channel interfaces for request words and serial bit words.
// Depends on lcdsf_pkg for the payload types.
interface lcdsf_req_if;
   logic                 valid;
   logic                 ready;
   lcdsf_pkg::req_type   payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface lcdsf_rsp_if;
   logic                 valid;
   logic                 ready;
   lcdsf_pkg::rsp_type   payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[rtl/lcdsf_frame_build.sv]
// Frame builder: turns one request word into a left-aligned bit frame and
// tracks whether a burst frame is open. Depends on lcdsf_pkg.
module lcdsf_frame_build (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  lcdsf_pkg::req_type  req,
   output logic                load_en,
   output lcdsf_pkg::load_type load
);
   import lcdsf_pkg::*;

   logic burst_open_ff;
   logic burst_open_in;
   logic op_valid;

   always_comb begin
      load          = '0;
      op_valid      = 1'b1;
      burst_open_in = burst_open_ff;
      unique case (req.opcode)
         OP_COMMAND: begin
            load.bits     = {CMD_PREAMBLE, req.command_code, 5'b0};
            load.count    = CMD_BITS;
            load.starts   = 1'b1;
            load.ends     = 1'b1;
            burst_open_in = 1'b0;
         end
         OP_SINGLE: begin
            load.bits     = {WRITE_PREAMBLE, req.address,
                             reverse_byte({4'b0, req.data_byte[3:0]})};
            load.count    = SINGLE_BITS;
            load.starts   = 1'b1;
            load.ends     = 1'b1;
            burst_open_in = 1'b0;
         end
         OP_BURST: begin
            if (burst_open_ff) begin
               load.bits   = {reverse_byte(req.data_byte), 9'b0};
               load.count  = BURST_DATA_BITS;
               load.starts = 1'b0;
            end else begin
               load.bits   = {WRITE_PREAMBLE, req.address, reverse_byte(req.data_byte)};
               load.count  = BURST_OPEN_BITS;
               load.starts = 1'b1;
            end
            load.ends     = req.last_of_burst;
            burst_open_in = ~req.last_of_burst;
         end
         default: begin
            op_valid = 1'b0;
         end
      endcase
   end

   assign load_en = accept & op_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         burst_open_ff <= 1'b0;
      end else if (load_en) begin
         burst_open_ff <= burst_open_in;
      end
   end

`ifndef SYNTHESIS
   a_close_clears: assert property (@(posedge clock) disable iff (reset)
      (load_en && req.opcode == OP_BURST && req.last_of_burst) |=> !burst_open_ff)
      else $error("burst still open after closing byte");
   a_open_no_start: assert property (@(posedge clock) disable iff (reset)
      (burst_open_ff && req.opcode == OP_BURST) |-> (!load.starts && load.count == BURST_DATA_BITS))
      else $error("open burst byte carries a header");
   a_frame_closes: assert property (@(posedge clock) disable iff (reset)
      (load_en && (req.opcode == OP_COMMAND || req.opcode == OP_SINGLE)) |=> !burst_open_ff)
      else $error("burst left open after a single frame");
`endif

endmodule

[rtl/lcdsf_bit_shifter.sv]
// Bit shifter and sequencer: one shift register and a down counter send the
// loaded frame one bit per output word. Depends on lcdsf_pkg.
module lcdsf_bit_shifter (
   input  logic                clock,
   input  logic                reset,
   input  logic                load_en,
   input  lcdsf_pkg::load_type load,
   input  logic                out_ready,
   output logic                out_valid,
   output lcdsf_pkg::rsp_type  out_word,
   output logic                idle
);
   import lcdsf_pkg::*;

   frame_type shift_ff;
   frame_type shift_in;
   count_type count_ff;
   count_type count_in;
   logic      first_ff;
   logic      first_in;
   logic      ends_ff;
   logic      ends_in;
   logic      final_bit;
   logic      advance;

   assign idle      = (count_ff == '0);
   assign out_valid = ~idle;
   assign final_bit = (count_ff == count_type'(1));
   assign advance   = out_valid & out_ready;

   assign out_word.data_bit    = shift_ff[FRAME_BITS-1];
   assign out_word.frame_start = first_ff;
   assign out_word.frame_end   = ends_ff & final_bit;
   assign out_word.last        = final_bit;

   always_comb begin
      shift_in = shift_ff;
      count_in = count_ff;
      first_in = first_ff;
      ends_in  = ends_ff;
      priority if (load_en) begin
         shift_in = load.bits;
         count_in = load.count;
         first_in = load.starts;
         ends_in  = load.ends;
      end else if (advance) begin
         shift_in = {shift_ff[FRAME_BITS-2:0], 1'b0};
         count_in = count_ff - count_type'(1);
         first_in = 1'b0;
      end else begin
         first_in = first_ff;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      ends_ff  <= ends_in;
      if (reset) begin
         count_ff <= '0;
         first_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         first_ff <= first_in;
      end
   end

`ifndef SYNTHESIS
   a_load_when_idle: assert property (@(posedge clock) disable iff (reset)
      load_en |-> idle)
      else $error("frame loaded while bits still pending");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= count_type'(FRAME_BITS))
      else $error("bit count out of range");
   a_drain_to_idle: assert property (@(posedge clock) disable iff (reset)
      (advance && final_bit) |=> idle)
      else $error("words remain after the final bit");
   a_start_once: assert property (@(posedge clock) disable iff (reset)
      (advance && !final_bit) |=> !out_word.frame_start)
      else $error("frame start on a later bit");
`endif

endmodule

[rtl/lcd_controller_serial_frame_tx_top.sv]
// Serial frame transmitter for a three-wire segment LCD controller: top level.
// Depends on lcdsf_pkg, lcdsf_if, lcdsf_frame_build and lcdsf_bit_shifter.
//
// Each request word becomes a run of one-bit output words, one per cycle when
// the sink is ready: 12 for a command, 13 for a single nibble write, 17 for the
// first byte of a burst and 8 for each later burst byte. The frame is loaded
// into one shift register and a down counter sets the run length; the request
// side is ready only when that register is empty. A word with an unused opcode
// is taken and produces no output. frame_start and frame_end tell the pin
// stage where chip select moves.
module lcd_controller_serial_frame_tx_top (
   input logic         clock,
   input logic         reset,
   lcdsf_req_if.sink   req_chan,
   lcdsf_rsp_if.source rsp_chan
);
   import lcdsf_pkg::*;

   logic     accept;
   logic     load_en;
   logic     idle;
   load_type load;

   assign req_chan.ready = idle;
   assign accept         = req_chan.valid & idle;

   lcdsf_frame_build u_frame_build (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .req     (req_chan.payload),
      .load_en (load_en),
      .load    (load)
   );

   lcdsf_bit_shifter u_bit_shifter (
      .clock     (clock),
      .reset     (reset),
      .load_en   (load_en),
      .load      (load),
      .out_ready (rsp_chan.ready),
      .out_valid (rsp_chan.valid),
      .out_word  (rsp_chan.payload),
      .idle      (idle)
   );

endmodule
